// File: design/decq_pkg.sv
package decq_pkg;

  // Configuration register indexes
  localparam int unsigned NumRegs = 8;
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_POWERON_SHORT = 3'd0;
  localparam reg_idx_t REG_POWERON_MID   = 3'd1;
  localparam reg_idx_t REG_POWERON_LONG  = 3'd2;
  localparam reg_idx_t REG_VOLT_LOW      = 3'd3;
  localparam reg_idx_t REG_VOLT_HIGH     = 3'd4;
  localparam reg_idx_t REG_BUSOFF_RECOV  = 3'd5;
  localparam reg_idx_t REG_PWR_DWELL     = 3'd6;
  localparam reg_idx_t REG_SPEED_LIMIT   = 3'd7;

  typedef logic [NumRegs-1:0][15:0] reg_file_t;

  // Reset values, index 0 in the lowest slot
  localparam reg_file_t RegResetValues = {
    16'd17, 16'd3000, 16'd1000, 16'd16500, 16'd8500, 16'd30000, 16'd15000, 16'd3000
  };

  // Bus mode and power mode codes
  localparam logic [1:0] MODE_FULL   = 2'd1;
  localparam logic [1:0] MODE_BUSOFF = 2'd2;
  localparam logic [7:0] PWR_ON      = 8'h02;

  // Flag update requested by one power-on timer for one beat
  typedef struct packed {
    logic set;
    logic clr;
    logic calib;
  } poweron_evt_t;

  // One result beat
  typedef struct packed {
    logic poweron_short_ok;
    logic poweron_mid_ok;
    logic poweron_long_ok;
    logic calib_request;
    logic voltage_normal;
    logic public_no_busoff;
    logic private_no_busoff;
    logic power_mode_ok;
    logic speed_nonzero;
  } result_t;

  // Wrapping elapsed time against delay minus task cycle, floored at zero
  function automatic logic time_passed(input logic [31:0] now, input logic [31:0] start,
                                       input logic [15:0] delay, input logic [15:0] cyc);
    logic [15:0] thr;
    logic [31:0] diff;
    thr  = (delay > cyc) ? (delay - cyc) : 16'd0;
    diff = now - start;
    return diff >= {16'd0, thr};
  endfunction

endpackage

// File: design/decq_poweron_timer.sv
module decq_poweron_timer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept_i,
  input  logic                   wake_i,
  input  logic                   stop_after_i,
  input  logic [31:0]            now_i,
  input  logic [15:0]            delay_i,
  input  logic [15:0]            task_cycle_i,
  output decq_pkg::poweron_evt_t evt_o
);

  typedef enum logic [1:0] {
    PH_INIT    = 2'd0,
    PH_COUNT   = 2'd1,
    PH_ELAPSED = 2'd2,
    PH_STOP    = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;

  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    evt_o       = '0;
    unique case (phase_r)
      PH_INIT: begin
        if (wake_i) begin
          start_nxt = now_i;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (decq_pkg::time_passed(now_i, start_r, delay_i, task_cycle_i)) begin
          phase_nxt = PH_ELAPSED;
        end else begin
          evt_o.clr = 1'b1;
        end
      end
      PH_ELAPSED: begin
        if (wake_i) begin
          evt_o.set = 1'b1;
          if (stop_after_i) begin
            evt_o.calib = 1'b1;
            phase_nxt   = PH_STOP;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
    end else if (accept_i) begin
      phase_r <= phase_nxt;
    end
    if (accept_i) begin
      start_r <= start_nxt;
    end
  end

  a_calib_stops: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && evt_o.calib |=> phase_r == PH_STOP)
    else $error("calibration request did not stop the timer");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && phase_r == PH_STOP |=> phase_r == PH_STOP)
    else $error("stopped timer left its stop phase");

  a_set_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt_o.set && evt_o.clr))
    else $error("timer asked to set and clear its flag together");

endmodule

// File: design/diag_enable_condition_qualifier_core.sv
// Diagnostic enable-condition qualifier.
//
// Input channel (in_valid/in_ready): one beat per periodic tick, carrying the
// timestamp in ms, the wakeup flag, battery mV, both CAN bus modes, the power
// mode byte and the raw speed. Result channel (out_valid/out_ready): one beat
// per input beat, carrying the nine qualifier flags including the one-beat
// calibration request.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr at once;
// write only while no beat is in flight.
// Results are registered. Throughput is one beat per cycle while in_ready is
// high: all timer, bus-off and compare logic is a single pass from the input
// ports into the state and result registers.
// A result register plus one skid register sit on the output, so an input
// beat is still taken while one result waits; in_ready drops only once both
// hold a result, and returns the cycle after the receiver takes one.
// Reset (synchronous, active low) loads the register defaults, puts all three
// power-on timers in their initial phase, clears every flag and the bus-off
// and power-mode marks, and empties the output stage.
module diag_enable_condition_qualifier_core #(
  parameter int unsigned TASK_CYCLE_MS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  input  logic        in_wakeup_valid,
  input  logic [15:0] in_battery_mv,
  input  logic [1:0]  in_public_bus_mode,
  input  logic [1:0]  in_private_bus_mode,
  input  logic [7:0]  in_power_mode,
  input  logic [15:0] in_speed_raw,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_poweron_short_ok,
  output logic        out_poweron_mid_ok,
  output logic        out_poweron_long_ok,
  output logic        out_calib_request,
  output logic        out_voltage_normal,
  output logic        out_public_no_busoff,
  output logic        out_private_no_busoff,
  output logic        out_power_mode_ok,
  output logic        out_speed_nonzero
);

  localparam logic [15:0] TaskCycle = 16'(TASK_CYCLE_MS);

  decq_pkg::reg_file_t    regs_r;
  logic                   accept;
  decq_pkg::poweron_evt_t evt_short, evt_mid, evt_long;

  // Flag registers, one bit per power-on, bus-off and power-mode condition
  logic short_f_r, mid_f_r, long_f_r, pwr_f_r;
  logic short_f_nxt, mid_f_nxt, long_f_nxt, volt_f_nxt, pwr_f_nxt, speed_f_nxt;
  logic [1:0]  bus_f_r, bus_f_nxt;
  logic [1:0]  bus_off_r, bus_off_nxt;
  logic [31:0] bus_start_r [2];
  logic [31:0] bus_start_nxt [2];
  logic [1:0]  bus_mode [2];

  logic        pwr_entered_r, pwr_entered_nxt;
  logic [31:0] pwr_start_r, pwr_start_nxt;

  decq_pkg::result_t res, out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              pop;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= decq_pkg::RegResetValues;
    end else if (cfg_wr_en) begin
      regs_r[cfg_addr] <= cfg_wdata;
    end
  end

  // Power-on timers; only the long one stops and pulses calibration
  decq_poweron_timer u_short (
    .clk, .rst_n, .accept_i(accept), .wake_i(in_wakeup_valid), .stop_after_i(1'b0),
    .now_i(in_now_ms), .delay_i(regs_r[decq_pkg::REG_POWERON_SHORT]),
    .task_cycle_i(TaskCycle), .evt_o(evt_short)
  );
  decq_poweron_timer u_mid (
    .clk, .rst_n, .accept_i(accept), .wake_i(in_wakeup_valid), .stop_after_i(1'b0),
    .now_i(in_now_ms), .delay_i(regs_r[decq_pkg::REG_POWERON_MID]),
    .task_cycle_i(TaskCycle), .evt_o(evt_mid)
  );
  decq_poweron_timer u_long (
    .clk, .rst_n, .accept_i(accept), .wake_i(in_wakeup_valid), .stop_after_i(1'b1),
    .now_i(in_now_ms), .delay_i(regs_r[decq_pkg::REG_POWERON_LONG]),
    .task_cycle_i(TaskCycle), .evt_o(evt_long)
  );

  assign bus_mode[0] = in_public_bus_mode;
  assign bus_mode[1] = in_private_bus_mode;

  always_comb begin
    // Power-on flags: set wins, clear otherwise, else hold
    short_f_nxt = evt_short.set ? 1'b1 : (evt_short.clr ? 1'b0 : short_f_r);
    mid_f_nxt   = evt_mid.set   ? 1'b1 : (evt_mid.clr   ? 1'b0 : mid_f_r);
    long_f_nxt  = evt_long.set  ? 1'b1 : (evt_long.clr  ? 1'b0 : long_f_r);

    // Voltage window, inclusive at both ends
    volt_f_nxt = (in_battery_mv >= regs_r[decq_pkg::REG_VOLT_LOW]) &&
                 (in_battery_mv <= regs_r[decq_pkg::REG_VOLT_HIGH]);

    // Bus-off qualifiers: bus-off marks and clears, full comm waits out the
    // quiet time, other modes hold
    for (int i = 0; i < 2; i++) begin
      bus_f_nxt[i]     = bus_f_r[i];
      bus_off_nxt[i]   = bus_off_r[i];
      bus_start_nxt[i] = bus_start_r[i];
      if (bus_mode[i] == decq_pkg::MODE_BUSOFF) begin
        bus_off_nxt[i]   = 1'b1;
        bus_start_nxt[i] = in_now_ms;
        bus_f_nxt[i]     = 1'b0;
      end else if (bus_mode[i] == decq_pkg::MODE_FULL) begin
        if (!bus_off_r[i]) begin
          bus_f_nxt[i] = 1'b1;
        end else if (decq_pkg::time_passed(in_now_ms, bus_start_r[i],
                                           regs_r[decq_pkg::REG_BUSOFF_RECOV],
                                           TaskCycle)) begin
          bus_off_nxt[i] = 1'b0;
          bus_f_nxt[i]   = 1'b1;
        end else begin
          bus_f_nxt[i] = 1'b0;
        end
      end
    end

    // Power mode dwell; the stored start drops to zero once the flag sets
    pwr_f_nxt       = pwr_f_r;
    pwr_entered_nxt = pwr_entered_r;
    pwr_start_nxt   = pwr_start_r;
    if (in_power_mode == decq_pkg::PWR_ON) begin
      if (!pwr_entered_r) begin
        pwr_start_nxt   = in_now_ms;
        pwr_entered_nxt = 1'b1;
      end else if (decq_pkg::time_passed(in_now_ms, pwr_start_r,
                                         regs_r[decq_pkg::REG_PWR_DWELL], TaskCycle)) begin
        pwr_f_nxt     = 1'b1;
        pwr_start_nxt = '0;
      end
    end else begin
      pwr_f_nxt       = 1'b0;
      pwr_entered_nxt = 1'b0;
    end

    speed_f_nxt = in_speed_raw > regs_r[decq_pkg::REG_SPEED_LIMIT];

    res.poweron_short_ok  = short_f_nxt;
    res.poweron_mid_ok    = mid_f_nxt;
    res.poweron_long_ok   = long_f_nxt;
    res.calib_request     = evt_long.calib;
    res.voltage_normal    = volt_f_nxt;
    res.public_no_busoff  = bus_f_nxt[0];
    res.private_no_busoff = bus_f_nxt[1];
    res.power_mode_ok     = pwr_f_nxt;
    res.speed_nonzero     = speed_f_nxt;
  end

  // Qualifier state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_f_r     <= 1'b0;
      mid_f_r       <= 1'b0;
      long_f_r      <= 1'b0;
      pwr_f_r       <= 1'b0;
      bus_f_r       <= '0;
      bus_off_r     <= '0;
      pwr_entered_r <= 1'b0;
      pwr_start_r   <= '0;
      bus_start_r   <= '{default: '0};
    end else if (accept) begin
      short_f_r     <= short_f_nxt;
      mid_f_r       <= mid_f_nxt;
      long_f_r      <= long_f_nxt;
      pwr_f_r       <= pwr_f_nxt;
      bus_f_r       <= bus_f_nxt;
      bus_off_r     <= bus_off_nxt;
      pwr_entered_r <= pwr_entered_nxt;
      pwr_start_r   <= pwr_start_nxt;
      bus_start_r   <= bus_start_nxt;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        out_r <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_poweron_short_ok  = out_r.poweron_short_ok;
  assign out_poweron_mid_ok    = out_r.poweron_mid_ok;
  assign out_poweron_long_ok   = out_r.poweron_long_ok;
  assign out_calib_request     = out_r.calib_request;
  assign out_voltage_normal    = out_r.voltage_normal;
  assign out_public_no_busoff  = out_r.public_no_busoff;
  assign out_private_no_busoff = out_r.private_no_busoff;
  assign out_power_mode_ok     = out_r.power_mode_ok;
  assign out_speed_nonzero     = out_r.speed_nonzero;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_calib_with_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_calib_request |-> out_poweron_long_ok)
    else $error("calibration request without long power-on flag");

  a_pwr_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_power_mode != decq_pkg::PWR_ON |=> !pwr_f_r && !pwr_entered_r)
    else $error("power mode flag survived a non-ON beat");

  a_busoff_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_public_bus_mode == decq_pkg::MODE_BUSOFF |=> !bus_f_r[0] && bus_off_r[0])
    else $error("public bus-off did not drop its flag");

endmodule
